### rtl/core/perceptron_neuron_sigmoid_defines.svh
// Assertion macros for the perceptron neuron. Each macro checks on the rising edge of clk
// and is switched off while arst_n is low.
`ifndef PERCEPTRON_NEURON_SIGMOID_DEFINES_SVH
`define PERCEPTRON_NEURON_SIGMOID_DEFINES_SVH
`ifndef SYNTHESIS
`define PNS_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);
`define PNS_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);
`else
`define PNS_ASSERT_IMP(lbl, ant, cons, msg)
`define PNS_ASSERT_NXT(lbl, ant, cons, msg)
`endif
`endif

### rtl/core/pns_pkg.sv
package pns_pkg;

	localparam int MAX_FEATURES_DEF   = 256;
	localparam int SIG_TABLE_SIZE_DEF = 1024;

	localparam int IDX_W   = 8;
	localparam int VAL_W   = 16;
	localparam int ACT_W   = 16;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACC_W   = 40;
	localparam int PRE_W   = ACC_W + 1;
	// x + 8 in Q.24 spans [0, 2^28)
	localparam int X_OFF_W = 28;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [ACT_W-1:0]        act_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [PRE_W-1:0] pre_t;

	typedef enum logic {
		OP_WEIGHT  = 1'b0,
		OP_FEATURE = 1'b1
	} op_e;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	// 8.0 in Q.24
	localparam pre_t X_HI = pre_t'(134217728);
	localparam pre_t X_LO = -X_HI;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] Q60_ONE = 64'd1 << 60;

	// Restoring long division, used only while building the sigmoid table.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^y for y in [0,1], Q30, from truncated Taylor terms
	function automatic logic [63:0] exp_unit(input logic [63:0] y);
		logic [63:0] term;
		logic [63:0] sum;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int k = 1; k <= 25; k++) begin
			term = udiv64((term * y) >> 30, 64'(k));
			sum  = sum + term;
		end
		return sum;
	endfunction

	localparam logic [63:0] EM1_Q30 = udiv64(Q60_ONE, exp_unit(Q30_ONE));

	// Sigmoid at the left edge of table slot idx, scaled to 65536, saturated.
	function automatic act_t sig_entry(input logic [63:0] idx, input logic [63:0] size);
		logic [63:0] pos;
		logic [63:0] t;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] d;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] s;
		logic        neg;
		pos = udiv64(idx << 34, size);
		neg = pos < (64'd1 << 33);
		t   = neg ? (64'd1 << 33) - pos : pos - (64'd1 << 33);
		n   = t >> 30;
		f   = t & (Q30_ONE - 64'd1);
		d   = udiv64(Q60_ONE, exp_unit(f));
		for (int j = 0; j < 8; j++) begin
			if (64'(j) < n) begin
				d = (d * EM1_Q30) >> 30;
			end
		end
		den = Q30_ONE + d;
		num = neg ? (d << 16) : (Q30_ONE << 16);
		s   = udiv64(num + (den >> 1), den);
		return (s > 64'd65535) ? '1 : s[ACT_W-1:0];
	endfunction

endpackage

### rtl/core/pns_if.sv
interface pns_req_if;
	import pns_pkg::*;
	logic   valid;
	logic   ready;
	logic   op;
	idx_t   element_index;
	value_t element_value;
	logic   last_element;
	modport source(output valid, output op, output element_index, output element_value,
		output last_element, input ready);
	modport sink(input valid, input op, input element_index, input element_value,
		input last_element, output ready);
endinterface

interface pns_res_if;
	import pns_pkg::*;
	logic valid;
	logic ready;
	act_t activation;
	logic sum_clamped;
	modport source(output valid, output activation, output sum_clamped, input ready);
	modport sink(input valid, input activation, input sum_clamped, output ready);
endinterface

interface pns_cfg_if;
	import pns_pkg::*;
	logic   valid;
	logic   ready;
	value_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/core/pns_ram.sv
module pns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/core/pns_sig_rom.sv
module pns_sig_rom #(
	parameter int SIZE = 1024
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [$clog2(SIZE)-1:0] addr,
	output pns_pkg::act_t           data
);
	import pns_pkg::*;

	act_t rom [SIZE];

	for (genvar i = 0; i < SIZE; i++) begin : g_rom
		localparam act_t ENTRY = sig_entry(64'(i), 64'(SIZE));
		assign rom[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom[addr];
		end
	end
endmodule

### rtl/core/perceptron_neuron_sigmoid.sv
// Perceptron neuron with a table sigmoid. Each request either writes one Q4.12 weight into the
// weight memory (op 0) or supplies one Q4.12 feature (op 1) that is multiplied by the weight at
// its index and added into a saturating 40-bit Q16.24 sum; a feature marked last adds the bias
// register, clamps the pre-activation to [-8,8), emits 65536/(1+e^-x) from a
// SIGMOID_TABLE_SIZE-entry ROM together with a clamp flag, and clears the sum. Weight writes and
// out-of-range indexes produce no result, but a last feature always does. Throughput is one
// request per cycle unless clearing or an output stall holds req.ready low. The weight memory
// is read once per feature and the single accumulator register takes a combinational saturated
// sum. A result passes the weight read, product, sum, offset, index and ROM registers after its
// last feature is taken. After reset the block clears the weight memory, one entry a cycle, and
// holds req.ready low until that pass ends; bias writes are taken at any time. A result waiting
// in the output register only blocks new requests once a second result reaches the ROM stage.
`include "perceptron_neuron_sigmoid_defines.svh"
module perceptron_neuron_sigmoid #(
	parameter int MAX_FEATURES       = pns_pkg::MAX_FEATURES_DEF,
	parameter int SIGMOID_TABLE_SIZE = pns_pkg::SIG_TABLE_SIZE_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pns_req_if.sink   req,
	pns_res_if.source res,
	pns_cfg_if.sink   cfg
);
	import pns_pkg::*;

	localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int TW = $clog2(SIGMOID_TABLE_SIZE);
	localparam int SW = X_OFF_W + TW + 1;

	// pipeline control
	logic en;
	logic req_fire;
	logic req_feat;
	logic req_hit;

	// weight memory clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	value_t bias_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [VAL_W-1:0] ram_rdata;

	logic   feat_s1;
	logic   hit_s1;
	logic   last_s1;
	value_t val_s1;

	logic                     feat_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2;

	acc_t              acc_q;
	logic signed [ACC_W:0] acc_sum;
	acc_t              acc_sat;

	logic v_s3;
	acc_t sum_s3;

	pre_t               pre_sum;
	pre_t               pre_off;
	logic               pre_lo;
	logic               pre_hi;
	logic [X_OFF_W-1:0] off_d;

	logic               v_s4;
	logic               clamped_s4;
	logic [X_OFF_W-1:0] off_s4;

	logic [SW-1:0] scaled;

	logic          v_s5;
	logic          clamped_s5;
	logic [TW-1:0] ti_s5;

	logic out_valid_q;
	logic clamped_q;
	act_t act_d;

	// Stall the request pipeline only when a result sits in the ROM stage and the output register
	// is full and not being taken.
	assign en        = !(v_s5 && out_valid_q && !res.ready);
	assign req.ready = !clr_q && en;
	assign req_fire  = req.valid && req.ready;
	assign req_feat  = req.op == OP_FEATURE;
	assign req_hit   = 32'(req.element_index) < 32'(MAX_FEATURES);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (cfg.valid) begin
			bias_q <= cfg.data;
		end
	end

	// Sweep zeros through the weight memory after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_FEATURES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Weight writes land at the request edge; a feature taken the next cycle already
	// reads the new value, so no forwarding is needed.
	assign ram_we    = clr_q || (req_fire && !req_feat && req_hit);
	assign ram_waddr = clr_q ? clr_addr_q : AW'(req.element_index);
	assign ram_wdata = clr_q ? '0 : req.element_value;

	pns_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_FEATURES)
	) u_weight_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (en),
		.raddr(AW'(req.element_index)),
		.rdata(ram_rdata)
	);

	// Stage 1: weight read in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_s1 <= 1'b0;
			hit_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else if (en) begin
			feat_s1 <= req_fire && req_feat;
			hit_s1  <= req_fire && req_feat && req_hit;
			last_s1 <= req.last_element;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s1 <= req.element_value;
		end
	end

	// Stage 2: product; an index beyond the memory contributes zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else if (en) begin
			feat_s2 <= feat_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= hit_s1 ? PROD_W'(val_s1 * $signed(ram_rdata)) : '0;
		end
	end

	// Accumulate with saturation at the 40-bit limits.
	always_comb begin
		acc_sum = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(prod_s2);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			v_s3  <= 1'b0;
		end else if (en) begin
			v_s3 <= feat_s2 && last_s2;
			if (feat_s2) begin
				acc_q <= last_s2 ? '0 : acc_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= acc_sat;
		end
	end

	// Stage 3: add bias in Q.24, clamp to [-8,8) and offset by 8.
	always_comb begin
		pre_sum = pre_t'(sum_s3) + (pre_t'(bias_q) <<< 12);
		pre_off = pre_sum + X_HI;
		pre_lo  = pre_sum < X_LO;
		pre_hi  = pre_sum >= X_HI;
		priority if (pre_lo) begin
			off_d = '0;
		end else if (pre_hi) begin
			off_d = '1;
		end else begin
			off_d = pre_off[X_OFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s4     <= off_d;
			clamped_s4 <= pre_lo || pre_hi;
		end
	end

	// Stage 4: scale the offset to a table index.
	assign scaled = SW'(off_s4) * SW'(SIGMOID_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ti_s5      <= scaled[X_OFF_W +: TW];
			clamped_s5 <= clamped_s4;
		end
	end

	// Stage 5: ROM read lands directly in the output register.
	pns_sig_rom #(
		.SIZE(SIGMOID_TABLE_SIZE)
	) u_sig_rom (
		.clk (clk),
		.en  (en && v_s5),
		.addr(ti_s5),
		.data(act_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && v_s5) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5) begin
			clamped_q <= clamped_s5;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.activation  = act_d;
	assign res.sum_clamped = clamped_q;

	`PNS_ASSERT_NXT(a_acc_clear, en && feat_s2 && last_s2, acc_q == '0,
		"running sum not cleared after last feature")
	`PNS_ASSERT_NXT(a_clr_no_req, clr_q, !feat_s1,
		"feature taken during weight memory clearing")
	`PNS_ASSERT_IMP(a_clamp_edge, v_s5 && clamped_s5,
		ti_s5 == '0 || ti_s5 == TW'(SIGMOID_TABLE_SIZE - 1),
		"clamped result not at a table edge")
	`PNS_ASSERT_NXT(a_rom_hold, v_s5 && !en, v_s5 && $stable(ti_s5),
		"stalled ROM stage lost its result")
endmodule
